// ===== hdl/gbi_pkg.sv =====
// Grid bilinear interpolator package: grid geometry, bank layout, shared types.
// Used by gbi_locate, gbi_blend and the top level; depends on nothing.
package gbi_pkg;

    localparam int GRID_ROWS   = 721;
    localparam int GRID_COLS   = 1440;
    localparam int GRID_SIZE   = GRID_ROWS * GRID_COLS;
    localparam int FRAC_W      = 10;
    localparam int NORTH_POLE  = 368640;
    localparam int ROW_MAX     = (GRID_ROWS - 1) * 1024;
    localparam int COL_SPAN    = GRID_COLS * 1024;

    // four banks split by row parity (msb) and column parity (lsb)
    localparam int BANK_COLS   = GRID_COLS / 2;
    localparam int EVEN_DEPTH  = ((GRID_ROWS + 1) / 2) * BANK_COLS;
    localparam int ODD_DEPTH   = (GRID_ROWS / 2) * BANK_COLS;
    localparam int ADDR_W      = $clog2(EVEN_DEPTH);
    localparam int NUM_BANKS   = 4;

    // entry_index / 1440 == (entry_index >> 5) * DIV45_MUL >> DIV45_SHIFT
    localparam int DIV45_MUL   = 46604;
    localparam int DIV45_SHIFT = 21;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
    } bank_req_t;

    typedef struct packed {
        logic [FRAC_W-1:0] fr;
        logic [FRAC_W-1:0] fc;
        logic              row_par;
        logic              col_par;
    } blend_ctl_t;

endpackage

// ===== hdl/gbi_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module gbi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/gbi_locate.sv =====
// Front stage: grid coordinates from a query, bank/address from a load, and
// the four bank requests for the memory stage. Depends on gbi_pkg.
module gbi_locate (
    input  logic                           clk,
    input  logic                           en,
    input  logic                           write_ok,
    input  logic                           op,
    input  logic signed [19:0]             latitude,
    input  logic signed [21:0]             longitude,
    input  logic [19:0]                    entry_index,
    input  logic signed [15:0]             entry_value,
    output gbi_pkg::op_t                   op_held,
    output gbi_pkg::bank_req_t             req [gbi_pkg::NUM_BANKS],
    output logic [15:0]                    wdata,
    output gbi_pkg::blend_ctl_t            ctl
);

    localparam logic signed [20:0] POLE   = 21'(gbi_pkg::NORTH_POLE);
    localparam logic signed [20:0] RMAX   = 21'(gbi_pkg::ROW_MAX);
    localparam logic signed [22:0] SPAN   = 23'(gbi_pkg::COL_SPAN);
    localparam logic [9:0]         LAST_R = 10'(gbi_pkg::GRID_ROWS - 1);
    localparam logic [10:0]        LAST_C = 11'(gbi_pkg::GRID_COLS - 1);
    localparam int                 AW     = gbi_pkg::ADDR_W;

    gbi_pkg::op_t  op_reg;
    logic [19:0]   r_reg;
    logic [20:0]   c_reg;
    logic [19:0]   idx_reg;
    logic [15:0]   value_reg;
    logic [9:0]    row_reg;
    logic          in_range_reg;

    logic signed [20:0] row_diff;
    logic [19:0]        r_next;
    logic signed [22:0] lon_ext;
    logic signed [22:0] col_wrap;
    logic [30:0]        quo;

    logic [9:0]    north;
    logic [9:0]    south_rd;
    logic [10:0]   west;
    logic [10:0]   east;
    logic [9:0]    row_up;
    logic [19:0]   load_addr;
    logic [9:0]    row_sel [gbi_pkg::NUM_BANKS];
    logic [10:0]   col_sel [gbi_pkg::NUM_BANKS];
    logic [AW-1:0] query_addr [gbi_pkg::NUM_BANKS];

    always_comb
    begin
        row_diff = POLE - $signed(21'(latitude));
        priority if (row_diff < 0)
            r_next = '0;
        else if (row_diff > RMAX)
            r_next = RMAX[19:0];
        else
            r_next = row_diff[19:0];

        lon_ext = 23'(longitude);
        priority if (lon_ext < -SPAN)
            col_wrap = lon_ext + SPAN + SPAN;
        else if (lon_ext < 0)
            col_wrap = lon_ext + SPAN;
        else if (lon_ext >= SPAN)
            col_wrap = lon_ext - SPAN;
        else
            col_wrap = lon_ext;

        quo = 31'(entry_index[19:5]) * 31'(gbi_pkg::DIV45_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg       <= gbi_pkg::op_t'(op);
            r_reg        <= r_next;
            c_reg        <= col_wrap[20:0];
            idx_reg      <= entry_index;
            value_reg    <= entry_value;
            row_reg      <= quo[30:gbi_pkg::DIV45_SHIFT];
            in_range_reg <= (entry_index < 20'(gbi_pkg::GRID_SIZE));
        end
    end

    // last row: south neighbor has zero weight, read row above to stay in bank
    always_comb
    begin
        north    = r_reg[19:10];
        west     = c_reg[20:10];
        south_rd = (north == LAST_R) ? north - 10'd1 : north + 10'd1;
        east     = (west == LAST_C) ? '0 : west + 11'd1;
        row_up   = 10'((11'(row_reg) + 11'd1) >> 1);
        load_addr = 20'(idx_reg[19:1]) - 20'(row_up) * 20'(gbi_pkg::BANK_COLS);

        for (int b = 0; b < gbi_pkg::NUM_BANKS; b++)
        begin
            row_sel[b]    = (north[0] == 1'(b >> 1)) ? north : south_rd;
            col_sel[b]    = (west[0] == 1'(b)) ? west : east;
            query_addr[b] = AW'(row_sel[b][9:1]) * AW'(gbi_pkg::BANK_COLS)
                          + AW'(col_sel[b][10:1]);
            req[b].we     = write_ok && (op_reg == gbi_pkg::OP_LOAD) && in_range_reg
                          && ({row_reg[0], idx_reg[0]} == 2'(b));
            req[b].addr   = (op_reg == gbi_pkg::OP_LOAD) ? load_addr[AW-1:0]
                                                          : query_addr[b];
        end
    end

    assign op_held     = op_reg;
    assign wdata       = value_reg;
    assign ctl.fr      = r_reg[9:0];
    assign ctl.fc      = c_reg[9:0];
    assign ctl.row_par = north[0];
    assign ctl.col_par = west[0];

endmodule

// ===== hdl/gbi_blend.sv =====
// Back stages: route bank data to corners, weight along columns, then rows,
// then round half-up to 1/256 cm. Depends on gbi_pkg.
module gbi_blend (
    input  logic                 clk,
    input  logic                 en_col,
    input  logic                 en_row,
    input  logic                 en_rnd,
    input  gbi_pkg::blend_ctl_t  ctl,
    input  logic signed [15:0]   bank_data [gbi_pkg::NUM_BANKS],
    output logic signed [23:0]   height
);

    localparam int FW = gbi_pkg::FRAC_W;

    logic signed [15:0] nw;
    logic signed [15:0] ne;
    logic signed [15:0] sw;
    logic signed [15:0] se;
    logic [FW:0]        wc0;
    logic [FW:0]        wr0;
    logic signed [27:0] p_nw;
    logic signed [27:0] p_ne;
    logic signed [27:0] p_sw;
    logic signed [27:0] p_se;
    logic signed [39:0] q_n;
    logic signed [39:0] q_s;
    logic signed [39:0] rnd;

    logic signed [27:0] row_n_reg;
    logic signed [27:0] row_s_reg;
    logic [FW-1:0]      fr_reg;
    logic signed [39:0] sum_reg;
    logic signed [23:0] height_reg;

    always_comb
    begin
        nw   = bank_data[{ ctl.row_par,  ctl.col_par}];
        ne   = bank_data[{ ctl.row_par, ~ctl.col_par}];
        sw   = bank_data[{~ctl.row_par,  ctl.col_par}];
        se   = bank_data[{~ctl.row_par, ~ctl.col_par}];
        wc0  = (FW+1)'(1 << FW) - (FW+1)'(ctl.fc);
        p_nw = nw * $signed({1'b0, wc0});
        p_ne = ne * $signed({2'b00, ctl.fc});
        p_sw = sw * $signed({1'b0, wc0});
        p_se = se * $signed({2'b00, ctl.fc});

        wr0  = (FW+1)'(1 << FW) - (FW+1)'(fr_reg);
        q_n  = row_n_reg * $signed({1'b0, wr0});
        q_s  = row_s_reg * $signed({2'b00, fr_reg});

        rnd  = sum_reg + 40'sd2048;
    end

    always_ff @(posedge clk)
    begin
        if (en_col)
        begin
            row_n_reg <= p_nw + p_ne;
            // zero row weight: south row may be one that was never read as a neighbor
            row_s_reg <= (ctl.fr == '0) ? '0 : p_sw + p_se;
            fr_reg    <= ctl.fr;
        end
        if (en_row)
        begin
            sum_reg <= q_n + q_s;
        end
        if (en_rnd)
        begin
            height_reg <= rnd[35:12];
        end
    end

    assign height = height_reg;

endmodule

// ===== hdl/grid_bilinear_interpolator.sv =====
// Grid bilinear interpolator top level: valid chain, four grid banks, stages.
// Depends on gbi_pkg, gbi_ram, gbi_locate, gbi_blend.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  item     | item_valid / item_stall    | op, latitude, longitude, entry_index,
//           |                            | entry_value
//  result   | result_valid / result_stall| height
//
// One beat per cycle in while item_stall is low, five register stages: input capture, bank read,
// column blend, row blend, rounding.
// Loads write one bank (none if entry_index is out of range) in the bank-read stage; no result.
// Grid banks are not cleared by reset; only the valid chain is.
// Each stage advances when it is empty or the next one advances, so a result
// stalled at the output only blocks the input once all five stages are full.
module grid_bilinear_interpolator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                op,
    input  logic signed [19:0]  latitude,
    input  logic signed [21:0]  longitude,
    input  logic [19:0]         entry_index,
    input  logic signed [15:0]  entry_value,
    output logic                result_valid,
    input  logic                result_stall,
    output logic signed [23:0]  height
);

    logic [5:1] valid_reg;
    logic [5:1] valid_next;
    logic [6:1] en;

    gbi_pkg::op_t        op_held;
    gbi_pkg::bank_req_t  req [gbi_pkg::NUM_BANKS];
    logic [15:0]         wdata;
    gbi_pkg::blend_ctl_t ctl_next;
    gbi_pkg::blend_ctl_t ctl_reg;
    logic signed [15:0]  bank_data [gbi_pkg::NUM_BANKS];

    always_comb
    begin
        en[6] = !result_stall;
        for (int k = 5; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end

        valid_next = valid_reg;
        if (en[1])
            valid_next[1] = item_valid;
        if (en[2])
            valid_next[2] = valid_reg[1] && (op_held == gbi_pkg::OP_QUERY);
        for (int k = 3; k <= 5; k++)
        begin
            if (en[k])
                valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
            ctl_reg <= ctl_next;
    end

    gbi_locate u_locate (
        .clk         (clk),
        .en          (en[1]),
        .write_ok    (valid_reg[1] && en[2]),
        .op          (op),
        .latitude    (latitude),
        .longitude   (longitude),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .op_held     (op_held),
        .req         (req),
        .wdata       (wdata),
        .ctl         (ctl_next)
    );

    for (genvar gb = 0; gb < gbi_pkg::NUM_BANKS; gb++)
    begin : g_bank
        localparam int BANK_DEPTH = (gb >= 2) ? gbi_pkg::ODD_DEPTH : gbi_pkg::EVEN_DEPTH;

        gbi_ram #(
            .WIDTH (16),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (req[gb].we),
            .re    (en[2]),
            .addr  (req[gb].addr),
            .wdata (wdata),
            .rdata (bank_data[gb])
        );
    end

    gbi_blend u_blend (
        .clk       (clk),
        .en_col    (en[3]),
        .en_row    (en[4]),
        .en_rnd    (en[5]),
        .ctl       (ctl_reg),
        .bank_data (bank_data),
        .height    (height)
    );

    assign item_stall   = !en[1];
    assign result_valid = valid_reg[5];

`ifndef NO_ASSERTIONS
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (&valid_reg && result_stall))
        else $error("input stalled while a stage was free");

    a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({req[3].we, req[2].we, req[1].we, req[0].we}))
        else $error("more than one bank written");

    a_write_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        (req[0].we || req[1].we || req[2].we || req[3].we)
            |-> (valid_reg[1] && en[2] && op_held == gbi_pkg::OP_LOAD))
        else $error("bank write without an advancing load");

    a_result_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg[5]) |-> $past(valid_reg[4]))
        else $error("result appeared without a row-blend beat");
`endif

endmodule
